>>> rtl/tree_path_page_address_generator_defines.svh
// Assertion macros used by the page address generator top level.
// Depends on nothing; the expanding module must provide clk and rst_n.
`ifndef TREE_PATH_PAGE_ADDRESS_GENERATOR_DEFINES_SVH
`define TREE_PATH_PAGE_ADDRESS_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TPAG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TPAG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tpag_pkg.sv
// Shared types and constants of the tree path page address generator.
// Used by tpag_addr_pipe and the top level; depends on nothing.
package tpag_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int PATH_W     = 63;
  localparam int SIZE_W     = 18;
  localparam int BYTES_W    = 17;
  localparam int LEVEL_W    = 3;
  localparam int SHIFT_W    = 7;
  localparam int PADDR_W    = 48;

  localparam logic [BYTES_W-1:0] BYTES_MAX = 17'h1FFFF;

  localparam logic [CFG_IDX_W-1:0] REG_TREE_LEVELS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_LEVEL_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVELS_INNER     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVELS_LEAF      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_BYTES      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEAF_BYTES       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TAG_BYTES        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CONTENTS_READY   = 3'd7;

  // Per-request control that travels with each level down the pipeline.
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               last;
    logic               not_ready;
    logic [SIZE_W-1:0]  size;
  } req_ctl_t;

endpackage

>>> rtl/tpag_addr_pipe.sv
// Three-stage address datapath: path shift, split multiply, final sum.
// Depends on tpag_pkg for the request control struct and field widths.
module tpag_addr_pipe #(
  parameter int ADDRESS_BITS = 48
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  tpag_pkg::req_ctl_t         in_ctl,
  input  logic [tpag_pkg::PATH_W-1:0]  in_path,
  input  logic [tpag_pkg::SHIFT_W-1:0] in_shift,
  input  logic [ADDRESS_BITS-1:0]    in_start,
  input  logic                       out_ready,
  output logic                       adv,
  output logic                       out_valid,
  output tpag_pkg::req_ctl_t         out_ctl,
  output logic [ADDRESS_BITS-1:0]    out_addr
);

  localparam int HALF = (ADDRESS_BITS + 1) / 2;
  localparam int HI_W = ADDRESS_BITS - HALF;
  localparam int SW   = tpag_pkg::SIZE_W;
  localparam int WIDE = ADDRESS_BITS + SW;

  // Stage A: page index.
  logic                     va_r;
  tpag_pkg::req_ctl_t       ctl_a_r;
  logic [ADDRESS_BITS-1:0]  idx_a_r, idx_a_nxt;
  logic [ADDRESS_BITS-1:0]  start_a_r;
  // Stage B: partial products.
  logic                     vb_r;
  tpag_pkg::req_ctl_t       ctl_b_r;
  logic [HALF+SW-1:0]       lo_b_r, lo_b_nxt;
  logic [HI_W+SW-1:0]       hi_b_r, hi_b_nxt;
  logic [ADDRESS_BITS-1:0]  start_b_r;
  // Stage C: output register.
  logic                     vc_r;
  tpag_pkg::req_ctl_t       ctl_c_r;
  logic [ADDRESS_BITS-1:0]  addr_c_r, addr_c_nxt;

  logic [63:0]   path_shifted;
  logic [WIDE-1:0] sum_wide;

  assign adv = !vc_r || out_ready;

  always_comb begin
    if (in_shift >= tpag_pkg::SHIFT_W'(63)) begin
      path_shifted = '0;
    end else begin
      path_shifted = {1'b0, in_path} >> in_shift;
    end
    idx_a_nxt = path_shifted[ADDRESS_BITS-1:0];
  end

  assign lo_b_nxt = idx_a_r[HALF-1:0] * ctl_a_r.size;
  assign hi_b_nxt = idx_a_r[ADDRESS_BITS-1:HALF] * ctl_a_r.size;

  always_comb begin
    sum_wide = WIDE'(start_b_r) + WIDE'(lo_b_r) + (WIDE'(hi_b_r) << HALF);
    addr_c_nxt = sum_wide[ADDRESS_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_a_r   <= in_ctl;
      idx_a_r   <= idx_a_nxt;
      start_a_r <= in_start;
      ctl_b_r   <= ctl_a_r;
      lo_b_r    <= lo_b_nxt;
      hi_b_r    <= hi_b_nxt;
      start_b_r <= start_a_r;
      ctl_c_r   <= ctl_b_r;
      addr_c_r  <= addr_c_nxt;
    end
  end

  assign out_valid = vc_r;
  assign out_ctl   = ctl_c_r;
  assign out_addr  = addr_c_r;

endmodule

>>> rtl/tree_path_page_address_generator.sv
// Tree path page address generator: configuration registers, level sequencer
// and output mapping. Depends on tpag_pkg, tpag_addr_pipe and the defines header.
//
// Usage: a leaf path is transferred on the in_ channel (valid/ready). For each
// page level, root first, one request leaves on the out_ channel with the page's
// byte address, its size including the tag, and last_request on the leaf page.
// If contents_ready is clear, a single refusal result (not_ready set) is sent.
// Registers are written through cfg_we/cfg_index/cfg_wdata; the user must write
// them only while the block is idle; the block does not enforce it. The root
// request is valid once it has passed the four pipeline registers. Throughput:
// one request per cycle while out_ready does not stall; a path occupies the
// level sequencer for page_level_count levels (clamped to 1..MAX_PAGE_LEVELS,
// one for a refusal). The next path is taken in the cycle the sequencer issues
// the current path's last level. The sequencer feeds a four-register pipeline:
// sequencer, page index, partial products, output register. A stall on out_ready
// freezes the whole pipeline and the sequencer; nothing is dropped or repeated.
// Reset (synchronous, rst_n low) empties the pipeline and loads register defaults.
`include "tree_path_page_address_generator_defines.svh"

module tree_path_page_address_generator #(
  parameter int MAX_PAGE_LEVELS = 8,
  parameter int ADDRESS_BITS    = 48
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tpag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpag_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tpag_pkg::PATH_W-1:0]     in_leaf_path,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tpag_pkg::LEVEL_W-1:0]    out_level_index,
  output logic [tpag_pkg::PADDR_W-1:0]    out_page_address,
  output logic [tpag_pkg::BYTES_W-1:0]    out_page_bytes,
  output logic                            out_not_ready,
  output logic                            out_last_request
);

  localparam int LW    = (MAX_PAGE_LEVELS > 1) ? $clog2(MAX_PAGE_LEVELS) : 1;
  localparam int EXP_W = $clog2(ADDRESS_BITS + 64);
  localparam int SW    = tpag_pkg::SIZE_W;

  // Configuration registers.
  logic [6:0]  tree_levels_r;
  logic [3:0]  page_level_count_r;
  logic [5:0]  lpi_r;
  logic [5:0]  lpl_r;
  logic [16:0] inner_bytes_r;
  logic [16:0] leaf_bytes_r;
  logic [6:0]  tag_bytes_r;
  logic        contents_ready_r;

  // Level sequencer.
  logic                        busy_r, busy_nxt;
  logic [tpag_pkg::PATH_W-1:0] path_r, path_nxt;
  logic [LW-1:0]               lvl_r, lvl_nxt;
  logic [tpag_pkg::SHIFT_W-1:0] shift_r, shift_nxt;
  logic [ADDRESS_BITS-1:0]     start_r, start_nxt;
  logic [EXP_W-1:0]            exp_r, exp_nxt;
  logic                        nr_r, nr_nxt;

  logic [3:0]          cnt;
  logic                last_lvl;
  logic [5:0]          lpp;
  logic [SW-1:0]       size;
  logic [EXP_W-1:0]    exp_sum;
  logic                adv;
  logic                emit;
  logic                in_acc;
  tpag_pkg::req_ctl_t  seq_ctl;
  tpag_pkg::req_ctl_t  out_ctl;
  logic [ADDRESS_BITS-1:0] out_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tree_levels_r      <= 7'd1;
      page_level_count_r <= 4'd1;
      lpi_r              <= 6'd1;
      lpl_r              <= 6'd1;
      inner_bytes_r      <= 17'd64;
      leaf_bytes_r       <= 17'd64;
      tag_bytes_r        <= 7'd16;
      contents_ready_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        tpag_pkg::REG_TREE_LEVELS:      tree_levels_r      <= cfg_wdata[6:0];
        tpag_pkg::REG_PAGE_LEVEL_COUNT: page_level_count_r <= cfg_wdata[3:0];
        tpag_pkg::REG_LEVELS_INNER:     lpi_r              <= cfg_wdata[5:0];
        tpag_pkg::REG_LEVELS_LEAF:      lpl_r              <= cfg_wdata[5:0];
        tpag_pkg::REG_INNER_BYTES:      inner_bytes_r      <= cfg_wdata;
        tpag_pkg::REG_LEAF_BYTES:       leaf_bytes_r       <= cfg_wdata;
        tpag_pkg::REG_TAG_BYTES:        tag_bytes_r        <= cfg_wdata[6:0];
        tpag_pkg::REG_CONTENTS_READY:   contents_ready_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (page_level_count_r == 4'd0) begin
      cnt = 4'd1;
    end else if (7'(page_level_count_r) > 7'(MAX_PAGE_LEVELS)) begin
      cnt = 4'(MAX_PAGE_LEVELS);
    end else begin
      cnt = page_level_count_r;
    end
  end

  assign last_lvl = nr_r || (7'(lvl_r) == (7'(cnt) - 7'd1));
  assign lpp      = last_lvl ? lpl_r : lpi_r;
  assign size     = SW'(last_lvl ? leaf_bytes_r : inner_bytes_r) + SW'(tag_bytes_r);
  assign exp_sum  = exp_r + EXP_W'(lpp);

  assign emit     = busy_r && adv;
  assign in_ready = adv && (!busy_r || last_lvl);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    busy_nxt  = busy_r;
    path_nxt  = path_r;
    lvl_nxt   = lvl_r;
    shift_nxt = shift_r;
    start_nxt = start_r;
    exp_nxt   = exp_r;
    nr_nxt    = nr_r;
    if (emit && last_lvl) begin
      busy_nxt = 1'b0;
    end
    if (in_acc) begin
      busy_nxt  = 1'b1;
      path_nxt  = in_leaf_path;
      lvl_nxt   = '0;
      shift_nxt = (tree_levels_r == 7'd0) ? 7'd0 : tree_levels_r - 7'd1;
      start_nxt = '0;
      exp_nxt   = '0;
      nr_nxt    = !contents_ready_r;
    end else if (emit) begin
      lvl_nxt   = lvl_r + LW'(1);
      // A shift that runs below zero behaves as zero, so it is held there.
      shift_nxt = (shift_r > 7'(lpp)) ? shift_r - 7'(lpp) : 7'd0;
      // The page count is a power of two; multiplying by it is a left shift.
      start_nxt = start_r + (ADDRESS_BITS'(size) << exp_r);
      exp_nxt   = (exp_sum > EXP_W'(ADDRESS_BITS)) ? EXP_W'(ADDRESS_BITS) : exp_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    path_r  <= path_nxt;
    lvl_r   <= lvl_nxt;
    shift_r <= shift_nxt;
    start_r <= start_nxt;
    exp_r   <= exp_nxt;
    nr_r    <= nr_nxt;
  end

  always_comb begin
    seq_ctl.level     = tpag_pkg::LEVEL_W'(lvl_r);
    seq_ctl.last      = last_lvl;
    seq_ctl.not_ready = nr_r;
    // A refusal carries size zero and start zero, so its address comes out zero.
    seq_ctl.size      = nr_r ? '0 : size;
  end

  tpag_addr_pipe #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_addr_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (busy_r),
    .in_ctl    (seq_ctl),
    .in_path   (path_r),
    .in_shift  (shift_r),
    .in_start  (start_r),
    .out_ready (out_ready),
    .adv       (adv),
    .out_valid (out_valid),
    .out_ctl   (out_ctl),
    .out_addr  (out_addr)
  );

  assign out_level_index  = out_ctl.level;
  assign out_page_address = tpag_pkg::PADDR_W'(out_addr);
  assign out_page_bytes   = out_ctl.size[SW-1] ? tpag_pkg::BYTES_MAX
                                               : out_ctl.size[SW-2:0];
  assign out_not_ready    = out_ctl.not_ready;
  assign out_last_request = out_ctl.last;

  `TPAG_ASSERT_NOW(a_accept_only_on_advance, in_ready, adv,
                   "input taken while the pipeline is stalled")
  `TPAG_ASSERT_NOW(a_refusal_shape, out_valid && out_not_ready,
                   out_last_request && out_level_index == '0 && out_page_bytes == '0,
                   "refusal result is not a single empty last request")
  `TPAG_ASSERT_NOW(a_level_in_range, busy_r, 7'(lvl_r) < 7'(cnt),
                   "sequencer level beyond the page level count")
  `TPAG_ASSERT_NEXT(a_stall_holds_sequencer, busy_r && !adv,
                    busy_r && $stable(lvl_r) && $stable(start_r),
                    "sequencer moved during a stall")
  `TPAG_ASSERT_NEXT(a_last_level_frees, emit && last_lvl && !in_acc, !busy_r,
                    "sequencer still busy after its last level")

endmodule

>>> test/tree_path_page_address_generator_tb.sv
// Self-checking testbench for the tree path page address generator.
// Depends on tpag_pkg and the tree_path_page_address_generator RTL; it needs no other file.
module tree_path_page_address_generator_tb;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 80;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_PATHS = 57;

  typedef struct packed {
    logic [tpag_pkg::LEVEL_W-1:0] level;
    logic [tpag_pkg::PADDR_W-1:0] address;
    logic [tpag_pkg::BYTES_W-1:0] bytes;
    logic                         not_ready;
    logic                         last;
  } page_request_t;

  // Holds a copy of the register file, predicts the page requests of each accepted
  // path and checks the requests that leave the block against them in order.
  class page_request_board;
    logic [6:0]  tree_levels;
    logic [3:0]  level_count;
    logic [5:0]  inner_levels;
    logic [5:0]  leaf_levels;
    logic [16:0] inner_bytes;
    logic [16:0] leaf_bytes;
    logic [6:0]  tag_bytes;
    logic        contents_ready;
    page_request_t expected_requests[$];
    int errors;

    function new();
      tree_levels = 1;
      level_count = 1;
      inner_levels = 1;
      leaf_levels = 1;
      inner_bytes = 64;
      leaf_bytes = 64;
      tag_bytes = 16;
      contents_ready = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [tpag_pkg::CFG_IDX_W-1:0] index,
                            logic [tpag_pkg::CFG_DATA_W-1:0] data);
      case (index)
        tpag_pkg::REG_TREE_LEVELS:      tree_levels = data[6:0];
        tpag_pkg::REG_PAGE_LEVEL_COUNT: level_count = data[3:0];
        tpag_pkg::REG_LEVELS_INNER:     inner_levels = data[5:0];
        tpag_pkg::REG_LEVELS_LEAF:      leaf_levels = data[5:0];
        tpag_pkg::REG_INNER_BYTES:      inner_bytes = data[16:0];
        tpag_pkg::REG_LEAF_BYTES:       leaf_bytes = data[16:0];
        tpag_pkg::REG_TAG_BYTES:        tag_bytes = data[6:0];
        tpag_pkg::REG_CONTENTS_READY:   contents_ready = data[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_requests.size();
    endfunction

    function void note_path(logic [tpag_pkg::PATH_W-1:0] path);
      int count;
      int shift;
      logic [63:0] start;
      logic [63:0] pages;
      logic [63:0] size;
      logic [63:0] index;
      logic [63:0] address;
      logic [5:0]  levels;
      logic        leaf;
      page_request_t req;
      if (!contents_ready) begin
        req = '{level: '0, address: '0, bytes: '0, not_ready: 1'b1, last: 1'b1};
        expected_requests.push_back(req);
        return;
      end
      count = (level_count == 0) ? 1 : (level_count > 8) ? 8 : int'(level_count);
      start = 0;
      pages = 1;
      shift = int'(tree_levels) - 1;
      for (int p = 0; p < count; p++) begin
        leaf = (p == count - 1);
        size = 64'(leaf ? leaf_bytes : inner_bytes) + 64'(tag_bytes);
        levels = leaf ? leaf_levels : inner_levels;
        // A shift at or below zero takes the whole path; one of 63 or more leaves nothing.
        if (shift <= 0) index = {1'b0, path};
        else if (shift >= 63) index = 0;
        else index = {1'b0, path} >> shift;
        address = start + index * size;
        req.level = p[tpag_pkg::LEVEL_W-1:0];
        req.address = address[tpag_pkg::PADDR_W-1:0];
        req.bytes = (size > 64'(tpag_pkg::BYTES_MAX)) ? tpag_pkg::BYTES_MAX
                                                      : size[tpag_pkg::BYTES_W-1:0];
        req.not_ready = 1'b0;
        req.last = leaf;
        expected_requests.push_back(req);
        shift = shift - int'(levels);
        start = start + pages * size;
        pages = pages << levels;
      end
    endfunction

    task report(string what);
      errors++;
      if (errors <= 30) $display("MISMATCH: %s", what);
    endtask

    task check_request(page_request_t got);
      page_request_t want;
      if (expected_requests.size() == 0) begin
        report($sformatf("request with nothing expected: level %0d address %h",
                         got.level, got.address));
        return;
      end
      want = expected_requests.pop_front();
      if (got.level !== want.level)
        report($sformatf("level_index %0d, expected %0d", got.level, want.level));
      if (got.address !== want.address)
        report($sformatf("page_address %h, expected %h (level %0d)",
                         got.address, want.address, want.level));
      if (got.bytes !== want.bytes)
        report($sformatf("page_bytes %0d, expected %0d (level %0d)",
                         got.bytes, want.bytes, want.level));
      if (got.not_ready !== want.not_ready)
        report($sformatf("not_ready %b, expected %b", got.not_ready, want.not_ready));
      if (got.last !== want.last)
        report($sformatf("last_request %b, expected %b (level %0d)",
                         got.last, want.last, want.level));
    endtask
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [tpag_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tpag_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           in_valid;
  logic                           in_ready;
  logic [tpag_pkg::PATH_W-1:0]    in_leaf_path;
  logic                           out_valid;
  logic                           out_ready;
  logic [tpag_pkg::LEVEL_W-1:0]   out_level_index;
  logic [tpag_pkg::PADDR_W-1:0]   out_page_address;
  logic [tpag_pkg::BYTES_W-1:0]   out_page_bytes;
  logic                           out_not_ready;
  logic                           out_last_request;

  page_request_board board;
  bit steady;
  bit hold_request;
  int quiet_cycles = 0;
  page_request_t seen;

  tree_path_page_address_generator DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_leaf_path     (in_leaf_path),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_level_index  (out_level_index),
    .out_page_address (out_page_address),
    .out_page_bytes   (out_page_bytes),
    .out_not_ready    (out_not_ready),
    .out_last_request (out_last_request)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random back-pressure or always ready, or one long hold-off when requested.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 34);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen = '{level: out_level_index, address: out_page_address, bytes: out_page_bytes,
               not_ready: out_not_ready, last: out_last_request};
      board.check_request(seen);
    end
  end

  // Ends the run if no transfer happens on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function int draw_gap();
    int n;
    n = 0;
    if (!steady)
      while (n < 20 && $urandom_range(99) < 34) n++;
    return n;
  endfunction

  // Mostly paths that fit the tree; now and then any 63-bit value.
  function logic [tpag_pkg::PATH_W-1:0] next_path();
    logic [tpag_pkg::PATH_W-1:0] path;
    int bits;
    path = tpag_pkg::PATH_W'({$urandom, $urandom});
    bits = int'(board.tree_levels) - 1;
    if ($urandom_range(99) < 85 && bits >= 0 && bits < tpag_pkg::PATH_W)
      path = path & ((63'd1 << bits) - 63'd1);
    return path;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task send_path(input logic [tpag_pkg::PATH_W-1:0] path);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_leaf_path <= path;
    do @(posedge clk); while (!in_ready);
    board.note_path(path);
    @(negedge clk);
  endtask

  task wait_drained();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Bits above the register's width are sometimes set; the block must ignore them.
  task write_reg(input logic [tpag_pkg::CFG_IDX_W-1:0] index, input int value,
                 input int width);
    logic [tpag_pkg::CFG_DATA_W-1:0] data;
    data = tpag_pkg::CFG_DATA_W'(value);
    if ($urandom_range(3) == 0)
      data = data | tpag_pkg::CFG_DATA_W'($urandom << width);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    board.write_reg(index, data);
    @(negedge clk);
  endtask

  task apply_setting(input int tree, input int count, input int inner, input int leaf,
                     input int inner_size, input int leaf_size, input int tag, input int ready);
    write_reg(tpag_pkg::REG_TREE_LEVELS, tree, 7);
    write_reg(tpag_pkg::REG_PAGE_LEVEL_COUNT, count, 4);
    write_reg(tpag_pkg::REG_LEVELS_INNER, inner, 6);
    write_reg(tpag_pkg::REG_LEVELS_LEAF, leaf, 6);
    write_reg(tpag_pkg::REG_INNER_BYTES, inner_size, 17);
    write_reg(tpag_pkg::REG_LEAF_BYTES, leaf_size, 17);
    write_reg(tpag_pkg::REG_TAG_BYTES, tag, 7);
    write_reg(tpag_pkg::REG_CONTENTS_READY, ready, 1);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function int draw_page_size();
    case ($urandom_range(3))
      0: return $urandom_range(1, 256);
      1: return 1 << $urandom_range(0, 16);
      2: return $urandom_range(1, 65536);
      default: return $urandom_range(0, 131071);
    endcase
  endfunction

  task random_setting();
    int tree, count, inner, leaf, tag, ready;
    tree = ($urandom_range(99) < 80) ? $urandom_range(1, 64) : $urandom_range(0, 127);
    count = ($urandom_range(99) < 80) ? $urandom_range(1, 8) : $urandom_range(0, 15);
    inner = ($urandom_range(99) < 80) ? $urandom_range(1, 8) : $urandom_range(0, 63);
    leaf = ($urandom_range(99) < 80) ? $urandom_range(1, 8) : $urandom_range(0, 63);
    tag = ($urandom_range(99) < 80) ? $urandom_range(0, 64) : $urandom_range(0, 127);
    ready = ($urandom_range(99) < 90);
    apply_setting(tree, count, inner, leaf, draw_page_size(), draw_page_size(), tag, ready);
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_leaf_path = '0;
    steady = 1'b0;
    hold_request = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Registers at their reset values: the contents are not ready yet.
    send_path('0);
    send_path('1);
    wait_drained();

    apply_setting(64, 8, 8, 8, 64, 128, 16, 1);
    send_path('0);
    send_path('1);
    send_path({21{3'b010}});
    send_path({21{3'b101}});
    send_path(63'd1);
    wait_drained();

    // Zero tree levels and zero page levels; page sizes that saturate the bytes field.
    apply_setting(0, 0, 1, 1, 131071, 131071, 127, 1);
    send_path('1);
    send_path(63'd12345);
    wait_drained();

    // Too many page levels, shifts of 63 or more, and page counts that overflow.
    apply_setting(127, 15, 63, 63, 1, 65536, 0, 1);
    send_path('1);
    send_path('0);
    send_path(next_path());
    wait_drained();

    // The running shift goes negative after the root page.
    apply_setting(1, 8, 1, 1, 65536, 1, 64, 1);
    send_path('1);
    send_path(63'd5);
    wait_drained();

    apply_setting(24, 3, 10, 4, 4096, 4096, 16, 0);
    send_path(next_path());
    send_path('1);
    wait_drained();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      random_setting();
      steady = (phase == 3 || phase == 5);
      // The long hold-off lets the pipeline fill so that the input stalls.
      if (phase == 5) hold_request = 1'b1;
      repeat (PHASE_PATHS) send_path(next_path());
      wait_drained();
    end
    steady = 1'b0;

    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
